// File: rtl/min_heap_priority_queue_assert.svh
// Assertion macros shared by the min-heap priority queue modules.
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define MHPQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhpq: assertion failed");
// Next-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhpq: assertion failed");
`else
`define MHPQ_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MHPQ_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/mhpq_pkg.sv
// Types and constants shared by the min-heap priority queue modules.
`default_nettype none
package mhpq_pkg;

  localparam int HEAP_DEPTH_DEFAULT = 1024;
  localparam int KEY_W = 32;
  localparam int TAG_W = 32;
  localparam int COUNT_W = 11;
  localparam int STATUS_W = 2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] entry_key;
    logic [TAG_W-1:0] entry_tag;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    removed_key;
    logic [TAG_W-1:0]    removed_tag;
    logic                min_valid;
    logic [KEY_W-1:0]    min_key;
    logic [TAG_W-1:0]    min_tag;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PUSH_LOAD,
    OP_POP_LOAD,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY,
    OP_READ_PARENT,
    OP_MOVE_PARENT,
    OP_PLACE,
    OP_POP_TAKE,
    OP_READ_CHILDREN,
    OP_MOVE_CHILD,
    OP_READ_ROOT,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_less;
    logic down_leaf;
    logic down_swap;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHECK,
    ST_UP_CMP,
    ST_POP_LD,
    ST_DOWN_CHECK,
    ST_DOWN_CMP,
    ST_ROOT_RD,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue.
//
// Input channel in_valid/in_stall/in_item carries one command per item: a push of a
// (key, tag) entry or a pop of the entry with the smallest key. Output channel
// out_valid/out_stall/out_item returns exactly one result item per command with
// the status, the removed entry, the new minimum and the entry count.
// The block works on one item at a time; in_stall is low only while it is idle.
// A pushed entry moves up at most log2(HEAP_DEPTH) levels and a popped one moves
// down at most one fewer. Each level costs one registered read of the heap
// memory and one compare and write. The next item can be accepted once the
// result register has been loaded.
// The result register holds a finished item while the receiver stalls; the next
// item can be accepted meanwhile and finishes once the register is taken.
// Reset clears the count, so the heap is empty right after reset; the memory
// itself is not cleared and needs no clearing pass.
`default_nettype none
module min_heap_priority_queue #(
  parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mhpq_pkg::out_item_t out_item
);

  mhpq_pkg::dp_op_t     op;
  mhpq_pkg::dp_status_t dp_status;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (in_item.command),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .op        (op)
  );

  mhpq_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .in_item   (in_item),
    .dp_status (dp_status),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// File: rtl/mhpq_ctrl.sv
// Controller state machine that sequences push, pop and sift steps.
`default_nettype none
`include "min_heap_priority_queue_assert.svh"
module mhpq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 command,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mhpq_pkg::dp_status_t dp_status,
  output mhpq_pkg::dp_op_t     op
);

  mhpq_pkg::state_t state;
  mhpq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = mhpq_pkg::OP_IDLE;
    unique case (state)
      mhpq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (command == mhpq_pkg::CMD_PUSH) begin
            if (dp_status.full) begin
              op = mhpq_pkg::OP_REFUSE_FULL;
              state_next = mhpq_pkg::ST_ROOT_RD;
            end else begin
              op = mhpq_pkg::OP_PUSH_LOAD;
              state_next = mhpq_pkg::ST_UP_CHECK;
            end
          end else begin
            if (dp_status.empty) begin
              op = mhpq_pkg::OP_REFUSE_EMPTY;
              state_next = mhpq_pkg::ST_ROOT_RD;
            end else begin
              op = mhpq_pkg::OP_POP_LOAD;
              state_next = mhpq_pkg::ST_POP_LD;
            end
          end
        end
      end
      mhpq_pkg::ST_UP_CHECK: begin
        if (dp_status.at_root) begin
          op = mhpq_pkg::OP_PLACE;
          state_next = mhpq_pkg::ST_ROOT_RD;
        end else begin
          op = mhpq_pkg::OP_READ_PARENT;
          state_next = mhpq_pkg::ST_UP_CMP;
        end
      end
      mhpq_pkg::ST_UP_CMP: begin
        if (dp_status.up_less) begin
          op = mhpq_pkg::OP_MOVE_PARENT;
          state_next = mhpq_pkg::ST_UP_CHECK;
        end else begin
          op = mhpq_pkg::OP_PLACE;
          state_next = mhpq_pkg::ST_ROOT_RD;
        end
      end
      mhpq_pkg::ST_POP_LD: begin
        op = mhpq_pkg::OP_POP_TAKE;
        state_next = mhpq_pkg::ST_DOWN_CHECK;
      end
      mhpq_pkg::ST_DOWN_CHECK: begin
        if (dp_status.down_leaf) begin
          op = mhpq_pkg::OP_PLACE;
          state_next = mhpq_pkg::ST_ROOT_RD;
        end else begin
          op = mhpq_pkg::OP_READ_CHILDREN;
          state_next = mhpq_pkg::ST_DOWN_CMP;
        end
      end
      mhpq_pkg::ST_DOWN_CMP: begin
        if (dp_status.down_swap) begin
          op = mhpq_pkg::OP_MOVE_CHILD;
          state_next = mhpq_pkg::ST_DOWN_CHECK;
        end else begin
          op = mhpq_pkg::OP_PLACE;
          state_next = mhpq_pkg::ST_ROOT_RD;
        end
      end
      mhpq_pkg::ST_ROOT_RD: begin
        op = mhpq_pkg::OP_READ_ROOT;
        state_next = mhpq_pkg::ST_DONE;
      end
      mhpq_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          op = mhpq_pkg::OP_OUT_LOAD;
          state_next = mhpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mhpq_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != mhpq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == mhpq_pkg::OP_OUT_LOAD) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `MHPQ_ASSERT_NXT(a_accept_starts_work, clk, rst, in_valid && !in_stall, state != mhpq_pkg::ST_IDLE)
  `MHPQ_ASSERT_IMP(a_load_needs_room, clk, rst, op == mhpq_pkg::OP_OUT_LOAD, !out_valid || !out_stall)
  `MHPQ_ASSERT_IMP(a_result_from_done, clk, rst, $rose(out_valid), $past(state) == mhpq_pkg::ST_DONE)

endmodule
`default_nettype wire

// File: rtl/mhpq_datapath.sv
// Datapath with the heap memory, the moving entry, the count and the result register.
`default_nettype none
`include "min_heap_priority_queue_assert.svh"
module mhpq_datapath #(
  parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mhpq_pkg::dp_op_t     op,
  input  mhpq_pkg::in_item_t   in_item,
  output mhpq_pkg::dp_status_t dp_status,
  output mhpq_pkg::out_item_t  out_item
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  mhpq_pkg::entry_t mem [HEAP_DEPTH];
  mhpq_pkg::entry_t rd_a;
  mhpq_pkg::entry_t rd_b;
  mhpq_pkg::entry_t moving;
  mhpq_pkg::entry_t removed;
  mhpq_pkg::entry_t wdata;
  mhpq_pkg::entry_t child;
  logic [mhpq_pkg::STATUS_W-1:0] res_status;
  logic [AW-1:0] pos;
  logic [AW-1:0] parent;
  logic [AW-1:0] last;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] pick_addr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_less;
  logic [CW:0]   left_w;
  logic [CW:0]   right_w;
  logic [CW:0]   count_w;
  logic [31:0]   count_wide;
  logic          pick_right;
  logic          mem_we;
  logic          rd_en;

  assign count_less = count - CW'(1);
  assign last = count_less[AW-1:0];
  assign parent = (pos - AW'(1)) >> 1;
  assign count_w = (CW + 1)'(count);
  assign left_w = ((CW + 1)'(pos) << 1) | (CW + 1)'(1);
  assign right_w = left_w + (CW + 1)'(1);
  assign pick_right = (right_w < count_w) && (rd_b.key < rd_a.key);
  assign child = pick_right ? rd_b : rd_a;
  assign pick_addr = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign count_wide = 32'(count);

  assign dp_status.full = (count == CW'(HEAP_DEPTH));
  assign dp_status.empty = (count == '0);
  assign dp_status.at_root = (pos == '0);
  assign dp_status.up_less = (moving.key < rd_a.key);
  assign dp_status.down_leaf = (left_w >= count_w);
  assign dp_status.down_swap = (moving.key > child.key);

  always_comb begin
    mem_we = 1'b0;
    wdata = moving;
    unique case (op)
      mhpq_pkg::OP_PLACE: begin
        mem_we = 1'b1;
      end
      mhpq_pkg::OP_MOVE_PARENT: begin
        mem_we = 1'b1;
        wdata = rd_a;
      end
      mhpq_pkg::OP_MOVE_CHILD: begin
        mem_we = 1'b1;
        wdata = child;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    addr_a = '0;
    addr_b = '0;
    unique case (op)
      mhpq_pkg::OP_POP_LOAD: begin
        rd_en = 1'b1;
        addr_b = last;
      end
      mhpq_pkg::OP_READ_PARENT: begin
        rd_en = 1'b1;
        addr_a = parent;
      end
      mhpq_pkg::OP_READ_CHILDREN: begin
        rd_en = 1'b1;
        addr_a = left_w[AW-1:0];
        addr_b = right_w[AW-1:0];
      end
      mhpq_pkg::OP_READ_ROOT: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos] <= wdata;
    end
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (op)
        mhpq_pkg::OP_PUSH_LOAD: count <= count + CW'(1);
        mhpq_pkg::OP_POP_LOAD: count <= count_less;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      mhpq_pkg::OP_PUSH_LOAD: begin
        moving.key <= in_item.entry_key;
        moving.tag <= in_item.entry_tag;
        pos <= count[AW-1:0];
        res_status <= mhpq_pkg::STATUS_OK;
        removed <= '0;
      end
      mhpq_pkg::OP_POP_LOAD: begin
        res_status <= mhpq_pkg::STATUS_OK;
      end
      mhpq_pkg::OP_REFUSE_FULL: begin
        res_status <= mhpq_pkg::STATUS_FULL;
        removed <= '0;
      end
      mhpq_pkg::OP_REFUSE_EMPTY: begin
        res_status <= mhpq_pkg::STATUS_EMPTY;
        removed <= '0;
      end
      mhpq_pkg::OP_MOVE_PARENT: begin
        pos <= parent;
      end
      mhpq_pkg::OP_POP_TAKE: begin
        removed <= rd_a;
        moving <= rd_b;
        pos <= '0;
      end
      mhpq_pkg::OP_MOVE_CHILD: begin
        pos <= pick_addr;
      end
      mhpq_pkg::OP_OUT_LOAD: begin
        out_item.status <= res_status;
        out_item.removed_key <= removed.key;
        out_item.removed_tag <= removed.tag;
        out_item.min_valid <= (count != '0);
        out_item.min_key <= (count != '0) ? rd_a.key : '0;
        out_item.min_tag <= (count != '0) ? rd_a.tag : '0;
        out_item.entry_count <= count_wide[mhpq_pkg::COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  `MHPQ_ASSERT_IMP(a_count_bounded, clk, rst, 1'b1, count <= CW'(HEAP_DEPTH))
  `MHPQ_ASSERT_NXT(a_push_counts_up, clk, rst, op == mhpq_pkg::OP_PUSH_LOAD, count == $past(count) + CW'(1))
  `MHPQ_ASSERT_NXT(a_min_valid_tracks, clk, rst, op == mhpq_pkg::OP_OUT_LOAD, out_item.min_valid == (count != '0))

endmodule
`default_nettype wire
